/* sv/csfd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csfd_pkg
// Shared types and protocol constants for the CAN serial frame deframer.
// ----------------------------------------------------------------------------
package csfd_pkg;

   // Protocol bytes
   localparam logic [7:0] SYNC_BYTE    = 8'hAA;
   localparam logic [7:0] FIXED_CMD    = 8'h55;
   localparam logic [7:0] PARAM_CMD_A  = 8'h04;
   localparam logic [7:0] PARAM_CMD_B  = 8'h06;
   localparam logic [3:0] STD_FRAME_HI = 4'hC;
   localparam logic [3:0] EXT_FRAME_HI = 4'hE;

   // Packet byte limit outside idle
   localparam logic [4:0] COMMAND_LENGTH = 5'd20;

   // Payload store
   localparam int PAYLOAD_DEPTH = 15;
   localparam int PAYLOAD_AW    = 4;

   localparam logic [2:0] STD_ID_BYTES = 3'd2;
   localparam logic [2:0] EXT_ID_BYTES = 3'd4;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_CMD,
      MODE_BUILD,
      MODE_PARAMS,
      MODE_EMIT_RD,
      MODE_EMIT_LD
   } mode_type;

endpackage

/* sv/can_serial_frame_deframer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_serial_frame_deframer_top
// Parses the adapter's serial byte stream and hands out each captured CAN
// frame as one transfer per data byte.
// ----------------------------------------------------------------------------
// Takes one serial byte per cycle on the req channel while parsing. When the
// last data byte of a frame arrives and capture is enabled, input is held off
// while the frame is replayed from the payload store: each data byte is read
// from the store and then loaded into the output register, and a load waits
// while the rsp side stalls. The single read port of the payload store sets
// that order. A result left in the output register does not block the next
// input byte.
module can_serial_frame_deframer_top (
   input  logic        clock,
   input  logic        reset,
   // serial bytes in
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   // frame bytes out
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_frame_id,
   output logic        rsp_is_extended,
   output logic [3:0]  rsp_payload_length,
   output logic [3:0]  rsp_byte_index,
   output logic [7:0]  rsp_data_byte,
   output logic        rsp_last,
   // control register
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_capture_enabled
);
   import csfd_pkg::*;

   mode_type mode_ff, mode_in;
   logic [4:0]  byte_count_ff, byte_count_in;
   logic [4:0]  frame_step_ff, frame_step_in;
   logic [31:0] id_ff, id_in;
   logic        ext_ff, ext_in;
   logic [3:0]  len_ff, len_in;
   logic [3:0]  emit_k_ff, emit_k_in;
   logic        capture_ff;

   logic [7:0]  payload_mem [PAYLOAD_DEPTH];
   logic [7:0]  rd_data_ff;
   logic        mem_wr_en, mem_rd_en;
   logic [PAYLOAD_AW-1:0] wr_addr;

   logic        rsp_valid_ff;
   logic [31:0] rsp_frame_id_ff;
   logic        rsp_ext_ff;
   logic [3:0]  rsp_len_ff;
   logic [3:0]  rsp_idx_ff;
   logic [7:0]  rsp_data_ff;
   logic        rsp_last_ff;
   logic        rsp_load;
   logic        emit_last;

   logic        req_accept;
   logic [2:0]  id_bytes;
   logic [4:0]  frame_end;
   logic [4:0]  last_step;
   logic [4:0]  data_pos;

   assign req_ready  = (mode_ff == MODE_IDLE) || (mode_ff == MODE_CMD) ||
                       (mode_ff == MODE_BUILD) || (mode_ff == MODE_PARAMS);
   assign req_accept = req_valid && req_ready;
   assign csr_ready  = 1'b1;

   assign id_bytes  = ext_ff ? EXT_ID_BYTES : STD_ID_BYTES;
   assign frame_end = {2'b00, id_bytes} + {1'b0, len_ff};
   assign last_step = frame_end - 5'd1;
   assign data_pos  = frame_step_ff - {2'b00, id_bytes};
   assign wr_addr   = data_pos[PAYLOAD_AW-1:0];
   assign emit_last = (emit_k_ff == (len_ff - 4'd1));

   always_comb begin
      mode_in       = mode_ff;
      byte_count_in = byte_count_ff;
      frame_step_in = frame_step_ff;
      id_in         = id_ff;
      ext_in        = ext_ff;
      len_in        = len_ff;
      emit_k_in     = emit_k_ff;
      mem_wr_en     = 1'b0;
      mem_rd_en     = 1'b0;
      rsp_load      = 1'b0;

      if (req_accept) begin
         byte_count_in = byte_count_ff + 5'd1;
      end

      unique case (mode_ff)
         MODE_IDLE: begin
            if (req_accept && req_rx_byte == SYNC_BYTE) begin
               mode_in       = MODE_CMD;
               byte_count_in = 5'd1;
            end
         end
         MODE_CMD: begin
            if (req_accept) begin
               priority if (req_rx_byte == FIXED_CMD) begin
                  mode_in = MODE_CMD;
               end else if (req_rx_byte == PARAM_CMD_A || req_rx_byte == PARAM_CMD_B) begin
                  mode_in = MODE_PARAMS;
               end else if (req_rx_byte[7:4] == STD_FRAME_HI ||
                            req_rx_byte[7:4] == EXT_FRAME_HI) begin
                  mode_in       = MODE_BUILD;
                  frame_step_in = 5'd0;
                  len_in        = req_rx_byte[3:0];
                  ext_in        = (req_rx_byte[7:4] == EXT_FRAME_HI);
               end else begin
                  // unknown command: keep looking for one
                  mode_in = MODE_CMD;
               end
            end
         end
         MODE_BUILD: begin
            if (req_accept) begin
               priority if (frame_step_ff < {2'b00, id_bytes}) begin
                  unique case (frame_step_ff[1:0])
                     2'd0: id_in = {24'd0, req_rx_byte};
                     2'd1: id_in[15:8]  = req_rx_byte;
                     2'd2: id_in[23:16] = req_rx_byte;
                     2'd3: id_in[31:24] = req_rx_byte;
                     default: id_in = id_ff;
                  endcase
                  frame_step_in = frame_step_ff + 5'd1;
               end else if (frame_step_ff < frame_end) begin
                  mem_wr_en = 1'b1;
                  if (frame_step_ff == last_step) begin
                     mode_in       = capture_ff ? MODE_EMIT_RD : MODE_IDLE;
                     emit_k_in     = 4'd0;
                     frame_step_in = 5'd0;
                  end else begin
                     frame_step_in = frame_step_ff + 5'd1;
                  end
               end else begin
                  // zero-length frame: byte after the ID closes it
                  mode_in       = MODE_IDLE;
                  frame_step_in = 5'd0;
               end
            end
         end
         MODE_PARAMS: begin
            mode_in = MODE_PARAMS;
         end
         MODE_EMIT_RD: begin
            mem_rd_en = 1'b1;
            mode_in   = MODE_EMIT_LD;
         end
         MODE_EMIT_LD: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               if (emit_last) begin
                  mode_in = MODE_IDLE;
               end else begin
                  emit_k_in = emit_k_ff + 4'd1;
                  mode_in   = MODE_EMIT_RD;
               end
            end
         end
         default: begin
            mode_in = MODE_IDLE;
         end
      endcase

      // packet byte limit, checked after the byte is handled
      if (req_accept && byte_count_in == COMMAND_LENGTH &&
          (mode_in == MODE_CMD || mode_in == MODE_BUILD || mode_in == MODE_PARAMS)) begin
         mode_in       = MODE_IDLE;
         frame_step_in = 5'd0;
         byte_count_in = 5'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         byte_count_ff <= 5'd0;
         frame_step_ff <= 5'd0;
         id_ff         <= 32'd0;
         ext_ff        <= 1'b0;
         len_ff        <= 4'd0;
         emit_k_ff     <= 4'd0;
         capture_ff    <= 1'b1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         mode_ff       <= mode_in;
         byte_count_ff <= byte_count_in;
         frame_step_ff <= frame_step_in;
         id_ff         <= id_in;
         ext_ff        <= ext_in;
         len_ff        <= len_in;
         emit_k_ff     <= emit_k_in;
         if (csr_valid && csr_ready) begin
            capture_ff <= csr_capture_enabled;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload store: write while parsing, read only while replaying
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         payload_mem[wr_addr] <= req_rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_rd_en) begin
         rd_data_ff <= payload_mem[emit_k_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_frame_id_ff <= id_ff;
         rsp_ext_ff      <= ext_ff;
         rsp_len_ff      <= len_ff;
         rsp_idx_ff      <= emit_k_ff;
         rsp_data_ff     <= rd_data_ff;
         rsp_last_ff     <= emit_last;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_frame_id       = rsp_frame_id_ff;
   assign rsp_is_extended    = rsp_ext_ff;
   assign rsp_payload_length = rsp_len_ff;
   assign rsp_byte_index     = rsp_idx_ff;
   assign rsp_data_byte      = rsp_data_ff;
   assign rsp_last           = rsp_last_ff;

endmodule

/* sv/csfd_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csfd_checker
// Port-level checks for the CAN serial frame deframer, bound to the top.
// ----------------------------------------------------------------------------
module csfd_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_ready,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_frame_id,
   input  logic        rsp_is_extended,
   input  logic [3:0]  rsp_payload_length,
   input  logic [3:0]  rsp_byte_index,
   input  logic [7:0]  rsp_data_byte,
   input  logic        rsp_last
);
   import csfd_pkg::*;

   // stalled transfer holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_frame_id) &&
      $stable(rsp_byte_index) && $stable(rsp_data_byte) && $stable(rsp_last))
      else $error("rsp payload changed while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload_length != 4'd0 &&
      {28'd0, rsp_payload_length} <= PAYLOAD_DEPTH &&
      rsp_byte_index < rsp_payload_length &&
      (rsp_last == (rsp_byte_index == rsp_payload_length - 4'd1)))
      else $error("byte index, length and last disagree");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_extended |-> rsp_frame_id[31:16] == 16'd0)
      else $error("standard frame carries upper ID bits");

   // input stays blocked until the whole frame has been replayed
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("input accepted in the middle of a frame replay");

   // next byte of a frame follows in order
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last ##1 rsp_valid |->
      rsp_byte_index == $past(rsp_byte_index) + 4'd1)
      else $error("frame bytes out of order");

endmodule

bind can_serial_frame_deframer_top csfd_checker u_csfd_checker (
   .clock              (clock),
   .reset              (reset),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_frame_id       (rsp_frame_id),
   .rsp_is_extended    (rsp_is_extended),
   .rsp_payload_length (rsp_payload_length),
   .rsp_byte_index     (rsp_byte_index),
   .rsp_data_byte      (rsp_data_byte),
   .rsp_last           (rsp_last)
);

/* tb/can_serial_frame_deframer_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_serial_frame_deframer_top_test
// Self-checking bench for the CAN serial frame deframer. Serial bytes are
// queued as directed packets and then random packets (frames, parameter
// replies, fixed commands, noise, truncated frames). An in-bench parser model
// predicts the per-byte frame results, which are checked field by field.
// Capture is toggled between phases, and both channels idle at random; one
// phase holds the result side off long enough to back up the input.
// ----------------------------------------------------------------------------
module can_serial_frame_deframer_top_test;
   import csfd_pkg::*;

   localparam int SETTLE_CYCLES = 40;    // covers a 15-byte replay
   localparam int LONG_HOLD     = 300;
   localparam int STALL_LIMIT   = 3000;
   localparam int MAX_PRINTS    = 50;

   typedef struct packed {
      logic [31:0] frame_id;
      logic        is_extended;
      logic [3:0]  payload_length;
      logic [3:0]  byte_index;
      logic [7:0]  data_byte;
      logic        last;
   } frame_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_frame_id;
   logic        rsp_is_extended;
   logic [3:0]  rsp_payload_length;
   logic [3:0]  rsp_byte_index;
   logic [7:0]  rsp_data_byte;
   logic        rsp_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_capture_enabled = 1'b1;

   // stimulus and expectations
   logic [7:0]  byte_queue[$];
   frame_byte_type frame_bytes_due[$];
   int          bytes_queued;
   int          error_count;
   int          bytes_parsed;
   int          results_checked;
   int          frames_captured;
   int          frames_discarded;

   // handshake flags, updated at the rising edge
   bit          req_took;
   bit          rsp_took;

   // idling control
   int          send_gap;
   int          send_stretch;
   bit          send_steady;
   int          take_stall;
   int          take_stretch;
   bit          take_steady;
   int          hold_left;
   bit          pressure_req;
   bit          pressure_done;
   int          quiet_cycles;

   // parser model state
   bit          capture_on;
   mode_type    parse_mode;
   logic [4:0]  pkt_count;
   logic [4:0]  frame_pos;
   logic [31:0] id_acc;
   logic        ext_frame;
   logic [3:0]  frame_len;
   logic [7:0]  data_hold [PAYLOAD_DEPTH];

   can_serial_frame_deframer_top DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_rx_byte         (req_rx_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_frame_id        (rsp_frame_id),
      .rsp_is_extended     (rsp_is_extended),
      .rsp_payload_length  (rsp_payload_length),
      .rsp_byte_index      (rsp_byte_index),
      .rsp_data_byte       (rsp_data_byte),
      .rsp_last            (rsp_last),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_capture_enabled (csr_capture_enabled)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(input string msg);
      if (error_count < MAX_PRINTS) begin
         $display("ERROR @%0t: %s", $realtime, msg);
      end
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
      end
   endtask

   // Stretches of back-to-back traffic are mixed at random with stretches of random waits.
   function automatic int draw_wait(inout int stretch, inout bit steady);
      if (stretch == 0) begin
         stretch = $urandom_range(10, 50);
         steady  = ($urandom_range(0, 2) == 0);
      end
      stretch--;
      return steady ? 0 : $urandom_range(0, 12);
   endfunction

   // Parser model: advances on one accepted byte, queues the frame bytes due.
   function automatic void parse_byte(input logic [7:0] c);
      int             id_len;
      int             pos;
      frame_byte_type fb;
      pkt_count = pkt_count + 5'd1;
      case (parse_mode)
         MODE_IDLE: begin
            if (c == SYNC_BYTE) begin
               parse_mode = MODE_CMD;
               pkt_count  = 5'd1;
            end
         end
         MODE_CMD: begin
            // fixed command keeps us in command mode; unknown bytes too
            if (c != FIXED_CMD) begin
               if (c == PARAM_CMD_A || c == PARAM_CMD_B) begin
                  parse_mode = MODE_PARAMS;
               end else if (c[7:4] == STD_FRAME_HI || c[7:4] == EXT_FRAME_HI) begin
                  parse_mode = MODE_BUILD;
                  frame_pos  = 5'd0;
                  frame_len  = c[3:0];
                  ext_frame  = (c[7:4] == EXT_FRAME_HI);
               end
            end
         end
         MODE_BUILD: begin
            id_len = ext_frame ? 4 : 2;
            pos    = int'(frame_pos);
            if (pos < id_len) begin
               if (pos == 0) begin
                  id_acc = {24'd0, c};
               end else begin
                  id_acc = id_acc | (32'(c) << (8 * pos));
               end
               frame_pos = frame_pos + 5'd1;
            end else if (pos < int'(frame_len) + id_len) begin
               data_hold[pos - id_len] = c;
               if (pos == int'(frame_len) + id_len - 1) begin
                  if (capture_on) begin
                     for (int k = 0; k < int'(frame_len); k++) begin
                        fb.frame_id       = id_acc;
                        fb.is_extended    = ext_frame;
                        fb.payload_length = frame_len;
                        fb.byte_index     = 4'(k);
                        fb.data_byte      = data_hold[k];
                        fb.last           = (k + 1 == int'(frame_len));
                        frame_bytes_due.push_back(fb);
                     end
                     frames_captured++;
                  end else begin
                     frames_discarded++;
                  end
                  parse_mode = MODE_IDLE;
                  frame_pos  = 5'd0;
               end else begin
                  frame_pos = frame_pos + 5'd1;
               end
            end else begin
               // zero-length frame: byte after the ID is swallowed
               parse_mode = MODE_IDLE;
               frame_pos  = 5'd0;
            end
         end
         default: begin
         end
      endcase
      if (parse_mode != MODE_IDLE && pkt_count == COMMAND_LENGTH) begin
         parse_mode = MODE_IDLE;
         frame_pos  = 5'd0;
         pkt_count  = 5'd0;
      end
   endfunction

   // Monitor, model update and watchdog
   always @(posedge clock) begin
      frame_byte_type want;
      bit             csr_took;
      if (reset) begin
         req_took     = 1'b0;
         rsp_took     = 1'b0;
         quiet_cycles = 0;
         capture_on   = 1'b1;
         parse_mode   = MODE_IDLE;
         pkt_count    = 5'd0;
         frame_pos    = 5'd0;
         id_acc       = 32'd0;
         ext_frame    = 1'b0;
         frame_len    = 4'd0;
         for (int i = 0; i < PAYLOAD_DEPTH; i++) begin
            data_hold[i] = 8'h00;
         end
      end else begin
         req_took = req_valid && req_ready;
         rsp_took = rsp_valid && rsp_ready;
         csr_took = csr_valid && csr_ready;
         if (csr_took) begin
            capture_on = csr_capture_enabled;
         end
         // results come from earlier bytes, so check before this edge's byte
         if (rsp_took) begin
            if (frame_bytes_due.size() == 0) begin
               report_mismatch($sformatf("unexpected result id 0x%0h index %0d",
                                         rsp_frame_id, rsp_byte_index));
            end else begin
               want = frame_bytes_due.pop_front();
               check_field("frame_id", rsp_frame_id, want.frame_id);
               check_field("is_extended", 32'(rsp_is_extended), 32'(want.is_extended));
               check_field("payload_length", 32'(rsp_payload_length),
                           32'(want.payload_length));
               check_field("byte_index", 32'(rsp_byte_index), 32'(want.byte_index));
               check_field("data_byte", 32'(rsp_data_byte), 32'(want.data_byte));
               check_field("last", 32'(rsp_last), 32'(want.last));
               results_checked++;
            end
         end
         if (req_took) begin
            parse_byte(req_rx_byte);
            bytes_parsed++;
         end
         if (req_took || rsp_took || csr_took) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results pending",
                     quiet_cycles, frame_bytes_due.size());
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // Byte driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid   <= 1'b0;
         req_rx_byte <= 8'h00;
      end else if (!req_valid || req_took) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (byte_queue.size() != 0) begin
            req_rx_byte <= byte_queue.pop_front();
            req_valid   <= 1'b1;
            send_gap = draw_wait(send_stretch, send_steady);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result receiver
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_took) begin
            take_stall = draw_wait(take_stretch, take_steady);
         end
         if (pressure_req && !pressure_done) begin
            hold_left     = LONG_HOLD;
            pressure_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (take_stall > 0) begin
            take_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic queue_byte(input logic [7:0] b);
      byte_queue.push_back(b);
      bytes_queued++;
   endtask

   task automatic write_capture(input bit on);
      @(negedge clock);
      csr_capture_enabled <= on;
      csr_valid           <= 1'b1;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_quiet();
      do @(posedge clock);
      while (byte_queue.size() != 0 || req_valid || frame_bytes_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Random packets: mostly well-formed frames, some truncated, parameter
   // replies that run to the byte limit, and loose noise bytes.
   task automatic queue_packets(input int budget, input bit frames_only);
      int         goal;
      int         kind;
      int         len;
      int         body;
      bit         ext;
      logic [7:0] b;
      goal = bytes_queued + budget;
      while (bytes_queued < goal) begin
         kind = frames_only ? 0 : $urandom_range(0, 99);
         if (kind < 70) begin
            queue_byte(SYNC_BYTE);
            if ($urandom_range(0, 4) == 0) begin
               if ($urandom_range(0, 1) == 0) begin
                  queue_byte(FIXED_CMD);
               end else begin
                  do b = 8'($urandom_range(0, 255));
                  while (b == FIXED_CMD || b == PARAM_CMD_A || b == PARAM_CMD_B ||
                         b[7:4] == STD_FRAME_HI || b[7:4] == EXT_FRAME_HI);
                  queue_byte(b);
               end
            end
            case ($urandom_range(0, 9))
               0:       len = $urandom_range(13, 15);
               1:       len = 0;
               default: len = $urandom_range(1, 8);
            endcase
            ext = $urandom_range(0, 1);
            queue_byte({ext ? EXT_FRAME_HI : STD_FRAME_HI, 4'(len)});
            body = (ext ? 4 : 2) + (len == 0 ? 1 : len);
            if (kind >= 60) begin
               body = $urandom_range(0, body - 1);   // cut short
            end
            repeat (body) queue_byte(8'($urandom_range(0, 255)));
         end else if (kind < 78) begin
            queue_byte(SYNC_BYTE);
            queue_byte($urandom_range(0, 1) ? PARAM_CMD_A : PARAM_CMD_B);
            repeat (18) queue_byte(8'($urandom_range(0, 255)));
         end else begin
            repeat ($urandom_range(1, 6)) queue_byte(8'($urandom_range(0, 255)));
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // standard frame, one byte, all-ones ID
      queue_byte(SYNC_BYTE); queue_byte(8'hC1);
      queue_byte(8'hFF); queue_byte(8'hFF); queue_byte(8'h00);
      // unknown command, fixed command, then extended frame of two bytes
      queue_byte(SYNC_BYTE); queue_byte(8'h13); queue_byte(FIXED_CMD);
      queue_byte(8'hE2);
      queue_byte(8'h00); queue_byte(8'h00); queue_byte(8'h00); queue_byte(8'h80);
      queue_byte(8'hFF); queue_byte(8'h7E);
      // zero-length frame swallows one byte
      queue_byte(SYNC_BYTE); queue_byte(8'hC0);
      queue_byte(8'h34); queue_byte(8'h12); queue_byte(8'h99);
      wait_quiet();

      write_capture(1'b0);
      queue_packets(90, 1'b0);
      wait_quiet();

      write_capture(1'b1);
      queue_packets(150, 1'b0);
      wait_quiet();

      // result side stalls for a long stretch while frames keep coming
      pressure_req = 1'b1;
      queue_packets(60, 1'b1);
      wait_quiet();

      write_capture(1'b0);
      queue_packets(40, 1'b0);
      wait_quiet();

      write_capture(1'b1);
      queue_packets(110, 1'b0);
      wait_quiet();

      if (frame_bytes_due.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", frame_bytes_due.size()));
      end
      $display("run: %0d serial bytes parsed, %0d frames captured, %0d discarded",
               bytes_parsed, frames_captured, frames_discarded);
      $display("run: %0d frame byte transfers checked, capture toggled 0/1 across phases",
               results_checked);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

/* filelist.f */
sv/csfd_pkg.sv
sv/can_serial_frame_deframer_top.sv
sv/csfd_checker.sv
tb/can_serial_frame_deframer_top_test.sv
